// ===== src/i2cmws_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package i2cmws_pkg;

    localparam logic [1:0] CMD_IDLE  = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_BYTE  = 2'd2;
    localparam logic [1:0] CMD_STOP  = 2'd3;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int IN_TDATA_W  = 16;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    localparam logic [4:0] START_TICKS = 5'd2;
    localparam logic [4:0] STOP_LAST   = 5'd2;
    localparam logic [4:0] BYTE_LAST   = 5'd28;
    localparam logic [4:0] ACK_LOW     = 5'd25;
    localparam logic [4:0] ACK_REL     = 5'd26;

    // classified input beat
    typedef struct packed {
        logic [1:0] kind;
        logic       load_shift;
        logic [7:0] shift_val;
        logic       sda_in;
    } item_t;

    // line levels for one tick of a byte sequence
    typedef struct packed {
        logic       use_prev;
        logic       force_one;
        logic [2:0] bit_pos;
        logic       scl;
    } byte_tick_t;

    function automatic byte_tick_t byte_tick(input logic [4:0] k);
        byte_tick_t t;
        int         i;
        t.use_prev  = 1'b0;
        t.force_one = 1'b1;
        t.bit_pos   = 3'd0;
        t.scl       = 1'b1;
        if (k == 5'd0 || k == ACK_LOW) begin
            t.use_prev = 1'b1;
            t.scl      = 1'b0;
        end else if (k == ACK_REL) begin
            t.scl = 1'b0;
        end
        for (i = 0; i < 8; i++) begin
            if (k == 5'(3 * i + 1) || k == 5'(3 * i + 2) || k == 5'(3 * i + 3)) begin
                t.force_one = 1'b0;
                t.bit_pos   = 3'(7 - i);
                t.scl       = (k == 5'(3 * i + 2));
            end
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== src/i2cmws_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cmws_front (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] data, [8] sda_in, [15:9] zero
    input  wire logic [i2cmws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  wire logic [i2cmws_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                    q_valid,
    input  wire logic                               q_ready,
    output i2cmws_pkg::item_t                       q_item
);
    import i2cmws_pkg::*;

    logic  valid_reg;
    item_t item_reg;
    item_t item_next;

    assign s_axis_tready = !valid_reg || q_ready;
    assign q_valid       = valid_reg;
    assign q_item        = item_reg;

    always_comb begin
        item_next.kind       = s_axis_tuser[1:0];
        item_next.sda_in     = s_axis_tdata[8];
        item_next.load_shift = (s_axis_tuser[1:0] == CMD_START) ||
                               (s_axis_tuser[1:0] == CMD_BYTE);
        if (s_axis_tuser[1:0] == CMD_START) begin
            item_next.shift_val = {s_axis_tdata[6:0], 1'b0};
        end else begin
            item_next.shift_val = s_axis_tdata[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/i2cmws_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cmws_queue #(
    parameter int DEPTH = i2cmws_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire i2cmws_pkg::item_t  in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output i2cmws_pkg::item_t       out_item
);
    import i2cmws_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign in_ready  = (count_reg != CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/i2cmws_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module i2cmws_back (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               q_valid,
    output logic                                    q_ready,
    input  wire i2cmws_pkg::item_t                  q_item,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] sda_out, [1] scl_out, [2] busy_res, [3] acked, [4] rejected,
    // [7:5] zero
    output logic [i2cmws_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // done_res
    output logic                                    m_axis_tlast
);
    import i2cmws_pkg::*;

    logic [4:0] phase_reg,  phase_next;
    logic [1:0] active_reg, active_next;
    logic [7:0] shift_reg,  shift_next;
    logic       prev_reg,   prev_next;
    logic       clk_reg,    clk_next;
    logic       m_valid_reg;
    logic       m_last_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg, m_data_next;

    logic       pop;
    logic       take;
    logic [1:0] cmd;
    logic [4:0] p;
    logic [4:0] k;
    logic       sda, scl, busy, done, acked, rejected;
    byte_tick_t bt;

    assign q_ready       = !m_valid_reg || m_axis_tready;
    assign pop           = q_valid && q_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;

    always_comb begin
        take     = (active_reg == CMD_IDLE) && (q_item.kind != CMD_IDLE);
        rejected = (active_reg != CMD_IDLE) && (q_item.kind != CMD_IDLE);
        cmd      = take ? q_item.kind : active_reg;
        p        = take ? 5'd0 : phase_reg;
        shift_next = (take && q_item.load_shift) ? q_item.shift_val : shift_reg;

        k  = (cmd == CMD_START) ? p - START_TICKS : p;
        bt = byte_tick(k);

        sda   = prev_reg;
        scl   = clk_reg;
        busy  = 1'b0;
        done  = 1'b0;
        acked = 1'b0;

        phase_next  = phase_reg;
        active_next = active_reg;
        prev_next   = prev_reg;
        clk_next    = clk_reg;

        if (cmd != CMD_IDLE) begin
            busy = 1'b1;
            if (cmd == CMD_STOP) begin
                sda  = (p >= STOP_LAST);
                scl  = (p != 5'd0);
                done = (p >= STOP_LAST);
            end else if (cmd == CMD_START && p < START_TICKS) begin
                sda = (p == 5'd0);
                scl = 1'b1;
            end else begin
                sda = bt.use_prev ? prev_reg :
                      bt.force_one ? 1'b1 : shift_next[bt.bit_pos];
                scl = bt.scl;
                if (k >= BYTE_LAST) begin
                    done  = 1'b1;
                    acked = !q_item.sda_in;
                end
            end
            prev_next = sda;
            clk_next  = scl;
            if (done) begin
                if (cmd != CMD_STOP) begin
                    prev_next = 1'b1;
                    clk_next  = 1'b0;
                end
                active_next = CMD_IDLE;
                phase_next  = 5'd0;
            end else begin
                active_next = cmd;
                phase_next  = p + 5'd1;
            end
        end

        m_data_next = {3'b000, rejected, acked, busy, scl, sda};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= 5'd0;
            active_reg  <= CMD_IDLE;
            shift_reg   <= 8'd0;
            prev_reg    <= 1'b1;
            clk_reg     <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                phase_reg  <= phase_next;
                active_reg <= active_next;
                shift_reg  <= shift_next;
                prev_reg   <= prev_next;
                clk_reg    <= clk_next;
            end
            if (q_ready) begin
                m_valid_reg <= q_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
            m_last_reg <= done;
        end
    end

    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_data_reg[2])
        else $error("done without busy");

    a_ack_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[3] |-> m_last_reg)
        else $error("acked outside done tick");

    a_rej_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg[4] |-> m_data_reg[2])
        else $error("reject while not busy");

    a_phase_rng: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg <= BYTE_LAST + START_TICKS)
        else $error("phase out of range");

    a_idle_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        active_reg == CMD_IDLE |-> phase_reg == 5'd0)
        else $error("phase not cleared when idle");

endmodule

`default_nettype wire

// ===== src/i2c_master_write_sequencer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Write-only I2C master line sequencer. Every input beat is one bus delay
// tick carrying the sampled SDA level and optionally a command in tuser
// (start with 7-bit address, send byte, stop); commands are taken only
// while no sequence runs, otherwise they are flagged as rejected. Every
// input beat yields exactly one output beat with the SDA/SCL levels to
// drive and status flags; tlast marks the last tick of a command sequence.
// One beat per clock is sustained in both directions while the output is
// not stalled; a beat passes an input register, a QUEUE_DEPTH-entry
// queue and the sequencer's output register. Input and output stall
// independently.
module i2c_master_write_sequencer #(
    parameter int QUEUE_DEPTH = i2cmws_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // [7:0] data, [8] sda_in, [15:9] zero
    input  wire logic [i2cmws_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [1:0] kind
    input  wire logic [i2cmws_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // [0] sda_out, [1] scl_out, [2] busy_res, [3] acked, [4] rejected,
    // [7:5] zero
    output logic [i2cmws_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // done_res
    output logic                                    m_axis_tlast
);
    import i2cmws_pkg::*;

    logic  f_valid, f_ready;
    item_t f_item;
    logic  b_valid, b_ready;
    item_t b_item;

    i2cmws_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (f_valid),
        .q_ready       (f_ready),
        .q_item        (f_item)
    );

    i2cmws_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_item   (f_item),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_item  (b_item)
    );

    i2cmws_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (b_valid),
        .q_ready       (b_ready),
        .q_item        (b_item),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire
